[hdl/psl_pkg.sv]
// Shared types, microcode codes and constants for the speed loop.
// No dependencies; the ROM, sequencer, datapath, top level and bench import this package.
package psl_pkg;

    localparam int STEP_W = 4;

    // datapath operations
    localparam logic [2:0] OP_NOP  = 3'd0;
    localparam logic [2:0] OP_LOAD = 3'd1;
    localparam logic [2:0] OP_ERR  = 3'd2;
    localparam logic [2:0] OP_SUM  = 3'd3;
    localparam logic [2:0] OP_LOOP = 3'd4;
    localparam logic [2:0] OP_RAMP = 3'd5;
    localparam logic [2:0] OP_OFF  = 3'd6;
    localparam logic [2:0] OP_OUT  = 3'd7;

    // multiplier operand selects
    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_PE   = 3'd1;   // prop_gain * error
    localparam logic [2:0] MUL_IS   = 3'd2;   // integ_gain * error sum
    localparam logic [2:0] MUL_DD   = 3'd3;   // deriv_gain * error delta
    localparam logic [2:0] MUL_SP   = 3'd4;   // speed * period
    localparam logic [2:0] MUL_RC   = 3'd5;   // product * reciprocal of 100

    // accumulator control
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    // sequencing conditions
    localparam logic [2:0] SEQ_NEXT     = 3'd0;
    localparam logic [2:0] SEQ_GOTO     = 3'd1;
    localparam logic [2:0] SEQ_WAIT_IN  = 3'd2;
    localparam logic [2:0] SEQ_IF_OFF   = 3'd3;
    localparam logic [2:0] SEQ_WAIT_OUT = 3'd4;

    // program addresses that are jump targets
    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DUTY = 4'd8;
    localparam logic [STEP_W-1:0] STEP_OFF  = 4'd11;

    // configuration register indexes
    localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [2:0] REG_INTEG_LIM  = 3'd3;
    localparam logic [2:0] REG_PWM_TOP    = 3'd4;

    localparam logic [6:0]  SPEED_MAX = 7'd100;
    // floor(x / 5) = (x * 205) >> 10 for x up to 100
    localparam logic [14:0] DIV5_MUL  = 15'd205;
    // floor(p / 100) = (p * ceil(2^30 / 100)) >> 30 for p below 2^23
    localparam logic [23:0] RECIP_100 = 24'd10737419;

    typedef struct packed {
        logic [2:0]        op;
        logic [2:0]        mul;
        logic [1:0]        acc;
        logic [2:0]        seq;
        logic [STEP_W-1:0] target;
    } t_ctl;

    typedef struct packed {
        logic drive_en;
        logic out_free;
    } t_stat;

endpackage

[hdl/psl_ucode_rom.sv]
// Control store of the speed loop: one control word per program step.
// Depends on psl_pkg for the control word type and codes.
module psl_ucode_rom (
    input  logic [psl_pkg::STEP_W-1:0] i_step,
    output psl_pkg::t_ctl              o_ctl
);
    import psl_pkg::*;

    always_comb begin
        unique case (i_step)
            4'd0:    o_ctl = '{OP_LOAD, MUL_NONE, ACC_HOLD, SEQ_WAIT_IN,  STEP_IDLE};
            4'd1:    o_ctl = '{OP_ERR,  MUL_NONE, ACC_HOLD, SEQ_IF_OFF,   STEP_OFF};
            4'd2:    o_ctl = '{OP_SUM,  MUL_PE,   ACC_HOLD, SEQ_NEXT,     STEP_IDLE};
            4'd3:    o_ctl = '{OP_NOP,  MUL_IS,   ACC_LOAD, SEQ_NEXT,     STEP_IDLE};
            4'd4:    o_ctl = '{OP_NOP,  MUL_DD,   ACC_ADD,  SEQ_NEXT,     STEP_IDLE};
            4'd5:    o_ctl = '{OP_NOP,  MUL_NONE, ACC_ADD,  SEQ_NEXT,     STEP_IDLE};
            4'd6:    o_ctl = '{OP_LOOP, MUL_NONE, ACC_HOLD, SEQ_NEXT,     STEP_IDLE};
            4'd7:    o_ctl = '{OP_RAMP, MUL_NONE, ACC_HOLD, SEQ_NEXT,     STEP_IDLE};
            4'd8:    o_ctl = '{OP_NOP,  MUL_SP,   ACC_HOLD, SEQ_NEXT,     STEP_IDLE};
            4'd9:    o_ctl = '{OP_NOP,  MUL_RC,   ACC_HOLD, SEQ_NEXT,     STEP_IDLE};
            4'd10:   o_ctl = '{OP_OUT,  MUL_NONE, ACC_HOLD, SEQ_WAIT_OUT, STEP_IDLE};
            4'd11:   o_ctl = '{OP_OFF,  MUL_NONE, ACC_HOLD, SEQ_GOTO,     STEP_DUTY};
            default: o_ctl = '{OP_NOP,  MUL_NONE, ACC_HOLD, SEQ_GOTO,     STEP_IDLE};
        endcase
    end

endmodule

[hdl/psl_sequencer.sv]
// Step counter of the speed loop: advances, waits or jumps per control word.
// Depends on psl_pkg for the control word, status struct and codes.
module psl_sequencer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  psl_pkg::t_ctl              i_ctl,
    input  psl_pkg::t_stat             i_stat,
    output logic [psl_pkg::STEP_W-1:0] o_step,
    output logic                       o_ready,
    output logic                       o_exec
);
    import psl_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [STEP_W-1:0] w_inc;

    assign w_inc   = r_step + 1'b1;
    assign o_step  = r_step;
    assign o_ready = (r_step == STEP_IDLE);

    always_comb begin
        o_exec = 1'b1;
        n_step = w_inc;
        unique case (i_ctl.seq)
            SEQ_NEXT: n_step = w_inc;
            SEQ_GOTO: n_step = i_ctl.target;
            SEQ_WAIT_IN: begin
                o_exec = i_valid;
                n_step = i_valid ? w_inc : r_step;
            end
            SEQ_IF_OFF: n_step = i_stat.drive_en ? w_inc : i_ctl.target;
            SEQ_WAIT_OUT: begin
                o_exec = i_stat.out_free;
                n_step = i_stat.out_free ? i_ctl.target : r_step;
            end
            default: n_step = STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

[hdl/psl_datapath.sv]
// Datapath of the speed loop: config registers, loop state, shared multiplier,
// accumulator and output register. Depends on psl_pkg for codes and constants.
module psl_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psl_pkg::t_ctl        i_ctl,
    input  logic                 i_exec,
    input  logic                 i_cfg_valid,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic [6:0]           i_speed_setpoint,
    input  logic                 i_drive_enable,
    input  logic                 i_ready,
    output psl_pkg::t_stat       o_stat,
    output logic                 o_valid,
    output logic [6:0]           o_speed_level,
    output logic [15:0]          o_duty_count,
    output logic signed [7:0]    o_speed_error,
    output logic [6:0]           o_loop_output
);
    import psl_pkg::*;

    // configuration
    logic signed [15:0] r_prop;
    logic signed [15:0] r_integ;
    logic signed [15:0] r_deriv_gain;
    logic [14:0]        r_limit;
    logic [15:0]        r_period;

    // loop state
    logic [6:0]         r_speed;
    logic signed [15:0] r_esum;
    logic signed [7:0]  r_perr;

    // working registers
    logic [6:0]         r_sp;
    logic               r_en;
    logic signed [7:0]  r_err;
    logic signed [8:0]  r_delta;
    logic signed [49:0] r_prod;
    logic signed [31:0] r_acc;
    logic [6:0]         r_loop;

    // output register
    logic               r_ov;
    logic [6:0]         r_o_speed;
    logic [15:0]        r_o_duty;
    logic signed [7:0]  r_o_err;
    logic [6:0]         r_o_loop;

    logic signed [24:0] w_ma;
    logic signed [24:0] w_mb;
    logic signed [49:0] w_prod;
    logic signed [16:0] w_sum;
    logic signed [16:0] w_lim;
    logic signed [16:0] w_sum_c;
    logic [23:0]        w_whole;
    logic [6:0]         w_loop;
    logic signed [7:0]  w_diff;
    logic [6:0]         w_mag;
    logic [14:0]        w_q15;
    logic [6:0]         w_step;
    logic               w_out_free;

    assign w_out_free = !r_ov || i_ready;
    assign o_stat     = '{drive_en: r_en, out_free: w_out_free};

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_ctl.mul)
            MUL_PE: begin
                w_ma = {{9{r_prop[15]}}, r_prop};
                w_mb = {{17{r_err[7]}}, r_err};
            end
            MUL_IS: begin
                w_ma = {{9{r_integ[15]}}, r_integ};
                w_mb = {{9{r_esum[15]}}, r_esum};
            end
            MUL_DD: begin
                w_ma = {{9{r_deriv_gain[15]}}, r_deriv_gain};
                w_mb = {{16{r_delta[8]}}, r_delta};
            end
            MUL_SP: begin
                w_ma = {18'd0, r_speed};
                w_mb = {9'd0, r_period};
            end
            MUL_RC: begin
                w_ma = {2'd0, r_prod[22:0]};
                w_mb = {1'b0, RECIP_100};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // error sum, clamped to plus or minus the limit
    assign w_sum = {r_esum[15], r_esum} + {{9{r_err[7]}}, r_err};
    assign w_lim = {2'b00, r_limit};
    always_comb begin
        if (w_sum > w_lim) begin
            w_sum_c = w_lim;
        end else if (w_sum < -w_lim) begin
            w_sum_c = -w_lim;
        end else begin
            w_sum_c = w_sum;
        end
    end

    // a negative sum truncates to zero or below, so it clamps to zero
    assign w_whole = r_acc[31:8];
    assign w_loop  = r_acc[31] ? 7'd0 :
                     (w_whole > {17'd0, SPEED_MAX}) ? SPEED_MAX : w_whole[6:0];

    // ramp: move a fifth of the gap, truncated toward zero
    assign w_diff = $signed({1'b0, r_loop}) - $signed({1'b0, r_speed});
    assign w_mag  = w_diff[7] ? 7'(-w_diff) : w_diff[6:0];
    assign w_q15  = {8'd0, w_mag} * DIV5_MUL;
    assign w_step = {2'd0, w_q15[14:10]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop       <= 16'sd256;
            r_integ      <= '0;
            r_deriv_gain <= '0;
            r_limit      <= 15'd1000;
            r_period     <= '0;
            r_speed      <= '0;
            r_esum       <= '0;
            r_perr       <= '0;
            r_en         <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_PROP_GAIN:  r_prop       <= i_cfg_data;
                    REG_INTEG_GAIN: r_integ      <= i_cfg_data;
                    REG_DERIV_GAIN: r_deriv_gain <= i_cfg_data;
                    REG_INTEG_LIM:  r_limit      <= i_cfg_data[14:0];
                    REG_PWM_TOP:    r_period     <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end

            if (i_exec) begin
                case (i_ctl.op)
                    OP_LOAD: begin
                        r_sp <= (i_speed_setpoint > SPEED_MAX) ? SPEED_MAX
                                                               : i_speed_setpoint;
                        r_en <= i_drive_enable;
                    end
                    OP_ERR: r_err <= $signed({1'b0, r_sp}) - $signed({1'b0, r_speed});
                    OP_SUM: begin
                        r_esum  <= w_sum_c[15:0];
                        r_delta <= {r_err[7], r_err} - {r_perr[7], r_perr};
                        r_perr  <= r_err;
                    end
                    OP_LOOP: r_loop <= w_loop;
                    OP_RAMP: r_speed <= w_diff[7] ? (r_speed - w_step) : (r_speed + w_step);
                    OP_OFF: begin
                        r_speed <= '0;
                        r_err   <= '0;
                        r_loop  <= '0;
                    end
                    OP_OUT: begin
                        r_ov      <= 1'b1;
                        r_o_speed <= r_speed;
                        r_o_duty  <= r_prod[45:30];
                        r_o_err   <= r_err;
                        r_o_loop  <= r_loop;
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_exec && (i_ctl.mul != MUL_NONE)) begin
            r_prod <= w_prod;
        end
        if (i_exec) begin
            case (i_ctl.acc)
                ACC_LOAD: r_acc <= r_prod[31:0];
                ACC_ADD:  r_acc <= r_acc + r_prod[31:0];
                default:  ;
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_speed_level = r_o_speed;
    assign o_duty_count  = r_o_duty;
    assign o_speed_error = r_o_err;
    assign o_loop_output = r_o_loop;

endmodule

[hdl/pid_speed_loop_with_ramp.sv]
// Speed PID loop with integral clamp and ramp limiter, microcoded.
// One word in flight: a new input word is accepted only after the previous one has
// run the program, which shares one multiplier and accumulator, and its result has
// entered the output register; a disabled word takes a shorter path through the program.
// Reset (synchronous, active low): gains, limit and period take their defaults,
// speed, error sum and previous error clear, the sequencer returns to idle.
module pid_speed_loop_with_ramp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    // input word channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [6:0]        i_speed_setpoint,
    input  logic              i_drive_enable,
    // result word channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic [6:0]        o_speed_level,
    output logic [15:0]       o_duty_count,
    output logic signed [7:0] o_speed_error,
    output logic [6:0]        o_loop_output
);
    import psl_pkg::*;

    // The program steps through: latch the word, form the error (branch to the
    // disable path when the drive is off), update the clamped error sum and
    // delta, run the three gain products through the shared multiplier into the
    // accumulator, clamp the loop output, ramp the speed, then form the duty
    // count as speed * period scaled by a reciprocal of 100, and hold the
    // result in the output register until the sink takes it.

    logic [STEP_W-1:0] w_step;
    t_ctl              w_ctl;
    t_stat             w_stat;
    logic              w_exec;

    // registers are always writable; the user must write only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    psl_ucode_rom u_rom (
        .i_step (w_step),
        .o_ctl  (w_ctl)
    );

    psl_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ctl   (w_ctl),
        .i_stat  (w_stat),
        .o_step  (w_step),
        .o_ready (o_ready),
        .o_exec  (w_exec)
    );

    psl_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl),
        .i_exec           (w_exec),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_speed_setpoint (i_speed_setpoint),
        .i_drive_enable   (i_drive_enable),
        .i_ready          (i_ready),
        .o_stat           (w_stat),
        .o_valid          (o_valid),
        .o_speed_level    (o_speed_level),
        .o_duty_count     (o_duty_count),
        .o_speed_error    (o_speed_error),
        .o_loop_output    (o_loop_output)
    );

endmodule

[hdl/psl_checker.sv]
// Port-level checks for the speed loop, bound to the top level.
// Depends only on the top level's ports.
module psl_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic [2:0]        i_cfg_index,
    input logic [15:0]       i_cfg_data,
    input logic              i_valid,
    input logic              o_ready,
    input logic [6:0]        i_speed_setpoint,
    input logic              i_drive_enable,
    input logic              o_valid,
    input logic              i_ready,
    input logic [6:0]        o_speed_level,
    input logic [15:0]       o_duty_count,
    input logic signed [7:0] o_speed_error,
    input logic [6:0]        o_loop_output
);

    // hold a stalled result word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_speed_level)
            && $stable(o_duty_count) && $stable(o_speed_error)
            && $stable(o_loop_output)))
        else $error("result word changed while stalled");

    // one word in flight: drop ready right after an accept
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after accept");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_speed_level <= 7'd100 && o_loop_output <= 7'd100
            && o_speed_error <= 8'sd100 && o_speed_error >= -8'sd100))
        else $error("result field out of range");

    a_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_speed_level == 7'd0) |-> (o_duty_count == 16'd0))
        else $error("duty nonzero at zero speed");

    // the program is at least six steps long
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> ##1 !o_ready)
        else $error("accepted a word too soon");

endmodule

bind pid_speed_loop_with_ramp psl_checker u_psl_checker (.*);

[test/pid_speed_loop_with_ramp_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for the speed PID loop: a directed table of ticks and register
// writes, then random ticks under random gains, limits and periods.
// Depends on psl_pkg and pid_speed_loop_with_ramp.
module pid_speed_loop_with_ramp_test;
    import psl_pkg::*;

    localparam int SETTLE_CYCLES = 4;     // idle cycles before touching registers
    localparam int END_CYCLES    = 24;    // watch for stray results at the end
    localparam int N_PHASES      = 31;
    localparam int PHASE_WORDS   = 50;
    localparam int RAMP_STEPS    = 5;     // speed closes one fifth of the gap per tick
    localparam longint Q8_ONE    = 256;   // 1.0 in Q8.8

    // indexes past the register list; a write there must change nothing
    localparam logic [2:0] REG_SPARE_LO  = REG_PWM_TOP + 3'd1;
    localparam logic [2:0] REG_SPARE_MID = REG_PWM_TOP + 3'd2;
    localparam logic [2:0] REG_SPARE_HI  = REG_PWM_TOP + 3'd3;

    typedef struct packed {
        logic [6:0]        speed;
        logic [15:0]       duty;
        logic signed [7:0] err;
        logic [6:0]        loop;
    } t_tick_result;

    // ROW_CHECK carries a result typed in by hand; ROW_WORD relies on the predictor
    typedef enum logic [1:0] {ROW_WORD, ROW_CHECK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind    kind;
        logic [2:0]   index;
        logic [15:0]  data;
        logic [6:0]   setpoint;
        logic         enable;
        t_tick_result want;
    } t_plan_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index = REG_PROP_GAIN;
    logic [15:0]       i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [6:0]        i_speed_setpoint = '0;
    logic              i_drive_enable = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [6:0]        o_speed_level;
    logic [15:0]       o_duty_count;
    logic signed [7:0] o_speed_error;
    logic [6:0]        o_loop_output;

    // predictor copy of the registers, at their reset values
    int          gain_p = 256;
    int          gain_i = 0;
    int          gain_d = 0;
    int          sum_limit = 1000;
    int unsigned period_top = 0;

    // predictor copy of the loop state
    int ramp_speed = 0;
    int err_sum = 0;
    int last_err = 0;

    t_tick_result expected_ticks[$];
    int           mismatch_count = 0;
    int           tick_count = 0;
    bit           quiet = 1'b0;     // suppress idling on both sides

    // Directed part: reset values, disable, setpoint saturation, gain and limit
    // extremes, a limit lowered under the held sum, and writes past the list.
    t_plan_row plan [43] = '{
        '{ROW_CHECK, '0, '0, 7'd0,   1'b0, '{7'd0,  16'd0, 8'sd0,   7'd0}},
        '{ROW_CHECK, '0, '0, 7'd100, 1'b1, '{7'd20, 16'd0, 8'sd100, 7'd100}},
        '{ROW_WORD,  '0, '0, 7'd127, 1'b1, '0},
        '{ROW_WORD,  '0, '0, 7'd101, 1'b1, '0},
        '{ROW_CHECK, '0, '0, 7'd64,  1'b0, '{7'd0,  16'd0, 8'sd0,   7'd0}},
        '{ROW_WORD,  '0, '0, 7'd100, 1'b1, '0},
        '{ROW_CFG,   REG_PWM_TOP,    16'hFFFF, '0, 1'b0, '0},
        '{ROW_WORD,  '0, '0, 7'd100, 1'b1, '0},
        '{ROW_CFG,   REG_PROP_GAIN,  16'h7FFF, '0, 1'b0, '0},
        '{ROW_CFG,   REG_INTEG_GAIN, 16'h7FFF, '0, 1'b0, '0},
        '{ROW_CFG,   REG_DERIV_GAIN, 16'h8000, '0, 1'b0, '0},
        '{ROW_WORD,  '0, '0, 7'd100, 1'b1, '0},
        '{ROW_WORD,  '0, '0, 7'd0,   1'b1, '0},
        '{ROW_WORD,  '0, '0, 7'd1,   1'b1, '0},
        '{ROW_CFG,   REG_PROP_GAIN,  16'h8000, '0, 1'b0, '0},
        '{ROW_CFG,   REG_INTEG_GAIN, 16'h8000, '0, 1'b0, '0},
        '{ROW_CFG,   REG_DERIV_GAIN, 16'h7FFF, '0, 1'b0, '0},
        '{ROW_WORD,  '0, '0, 7'd100, 1'b1, '0},
        '{ROW_WORD,  '0, '0, 7'd0,   1'b1, '0},
        '{ROW_WORD,  '0, '0, 7'd127, 1'b1, '0},
        '{ROW_CFG,   REG_INTEG_LIM,  16'hFFFF, '0, 1'b0, '0},
        '{ROW_WORD,  '0, '0, 7'd100, 1'b1, '0},
        '{ROW_CFG,   REG_INTEG_LIM,  16'h0000, '0, 1'b0, '0},
        '{ROW_CFG,   REG_PROP_GAIN,  16'h0100, '0, 1'b0, '0},
        '{ROW_CFG,   REG_INTEG_GAIN, 16'h0100, '0, 1'b0, '0},
        '{ROW_CFG,   REG_DERIV_GAIN, 16'h0100, '0, 1'b0, '0},
        '{ROW_WORD,  '0, '0, 7'd100, 1'b1, '0},
        '{ROW_WORD,  '0, '0, 7'd42,  1'b1, '0},
        '{ROW_CFG,   REG_INTEG_LIM,  16'd1000, '0, 1'b0, '0},
        '{ROW_CFG,   REG_INTEG_GAIN, 16'd1,    '0, 1'b0, '0},
        '{ROW_CFG,   REG_DERIV_GAIN, 16'd0,    '0, 1'b0, '0},
        '{ROW_WORD,  '0, '0, 7'd100, 1'b1, '0},
        '{ROW_WORD,  '0, '0, 7'd100, 1'b1, '0},
        '{ROW_WORD,  '0, '0, 7'd100, 1'b1, '0},
        '{ROW_WORD,  '0, '0, 7'd100, 1'b1, '0},
        '{ROW_CFG,   REG_INTEG_LIM,  16'd3,    '0, 1'b0, '0},
        '{ROW_WORD,  '0, '0, 7'd100, 1'b1, '0},
        '{ROW_WORD,  '0, '0, 7'd55,  1'b1, '0},
        '{ROW_CFG,   REG_SPARE_LO,   16'hFFFF, '0, 1'b0, '0},
        '{ROW_CFG,   REG_SPARE_MID,  16'hFFFF, '0, 1'b0, '0},
        '{ROW_CFG,   REG_SPARE_HI,   16'hFFFF, '0, 1'b0, '0},
        '{ROW_WORD,  '0, '0, 7'd100, 1'b1, '0},
        '{ROW_CHECK, '0, '0, 7'd0,   1'b0, '{7'd0,  16'd0, 8'sd0,   7'd0}}
    };

    pid_speed_loop_with_ramp dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_speed_setpoint (i_speed_setpoint),
        .i_drive_enable   (i_drive_enable),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_speed_level    (o_speed_level),
        .o_duty_count     (o_duty_count),
        .o_speed_error    (o_speed_error),
        .o_loop_output    (o_loop_output)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Advance the predicted loop by one tick and return the word it should emit.
    function automatic t_tick_result step_speed_loop(input logic [6:0] setpoint,
                                                     input logic enable);
        int           target;
        int           err;
        int           sum;
        int           loop_val;
        int           ramp;
        longint       acc;
        longint       whole;
        t_tick_result r;
        target = (setpoint > SPEED_MAX) ? int'(SPEED_MAX) : int'(setpoint);
        err = 0;
        loop_val = 0;
        if (!enable) begin
            // drop the speed, hold the error history
            ramp_speed = 0;
        end else begin
            err = target - ramp_speed;
            sum = err_sum + err;
            if (sum > sum_limit)
                sum = sum_limit;
            if (sum < -sum_limit)
                sum = -sum_limit;
            err_sum = sum;
            acc = longint'(gain_p) * err + longint'(gain_i) * sum
                + longint'(gain_d) * (err - last_err);
            whole = acc / Q8_ONE;   // truncates toward zero
            if (whole > longint'(SPEED_MAX))
                whole = SPEED_MAX;
            if (whole < 0)
                whole = 0;
            loop_val = int'(whole);
            last_err = err;
            ramp = (loop_val - ramp_speed) / RAMP_STEPS;
            ramp_speed += ramp;
            if (ramp_speed > int'(SPEED_MAX))
                ramp_speed = SPEED_MAX;
            if (ramp_speed < 0)
                ramp_speed = 0;
        end
        r.speed = 7'(ramp_speed);
        r.duty  = 16'((ramp_speed * period_top) / 100);
        r.err   = 8'(err);
        r.loop  = 7'(loop_val);
        return r;
    endfunction

    function automatic void apply_reg(input logic [2:0] index, input logic [15:0] data);
        case (index)
            REG_PROP_GAIN:  gain_p = int'($signed(data));
            REG_INTEG_GAIN: gain_i = int'($signed(data));
            REG_DERIV_GAIN: gain_d = int'($signed(data));
            REG_INTEG_LIM:  sum_limit = int'(data[14:0]);
            REG_PWM_TOP:    period_top = data;
            default: ;
        endcase
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [15:0] pick_gain(input int reach);
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 2 * reach)) - reach);
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 2000));
        endcase
    endfunction

    function automatic logic [15:0] pick_period();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("ERROR at %0t, result word %0d: %s", $time, tick_count, what);
    endtask

    // Present one tick word and queue its expected result once it is taken.
    // Valid stays high on return; the next call or settle() decides its fate.
    task automatic send_tick(input logic [6:0] setpoint, input logic enable,
                             input bit fixed, input t_tick_result want);
        int           gap;
        t_tick_result predicted;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_speed_setpoint <= setpoint;
        i_drive_enable   <= enable;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        predicted = step_speed_loop(setpoint, enable);
        expected_ticks.push_back(fixed ? want : predicted);
    endtask

    // Drop valid and wait until every result is back, so the block sits idle.
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write, preceded by an idle gap that keeps valid edges clean.
    task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
        int gap;
        gap = 1 + pick_gap();
        repeat (gap) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        apply_reg(index, data);
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: stall at random, take each word and check it field by field.
    initial begin
        int           gap;
        t_tick_result got;
        t_tick_result want;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
            got = '{o_speed_level, o_duty_count, o_speed_error, o_loop_output};
            tick_count++;
            if (expected_ticks.size() == 0) begin
                report_mismatch("result word with nothing pending");
            end else begin
                want = expected_ticks.pop_front();
                if (got.speed !== want.speed)
                    report_mismatch($sformatf("speed_level %0d, expected %0d",
                                              got.speed, want.speed));
                if (got.duty !== want.duty)
                    report_mismatch($sformatf("duty_count %0d, expected %0d",
                                              got.duty, want.duty));
                if (got.err !== want.err)
                    report_mismatch($sformatf("speed_error %0d, expected %0d",
                                              got.err, want.err));
                if (got.loop !== want.loop)
                    report_mismatch($sformatf("loop_output %0d, expected %0d",
                                              got.loop, want.loop));
            end
        end
    end

    // Stimulus: reset, the directed table, then random phases.
    initial begin
        bit         in_flight;
        logic [6:0] target;
        logic       enable;
        in_flight = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the table; drain before any register write so the loop is idle.
        foreach (plan[row]) begin
            if (plan[row].kind == ROW_CFG) begin
                if (in_flight) begin
                    settle();
                    in_flight = 1'b0;
                end
                write_reg(plan[row].index, plan[row].data);
            end else begin
                send_tick(plan[row].setpoint, plan[row].enable,
                          plan[row].kind == ROW_CHECK, plan[row].want);
                in_flight = 1'b1;
            end
        end

        // Each phase: new settings, then ticks that hold a setpoint for a while so the
        // speed can ramp and the error sum can build up against its limit.
        for (int phase = 0; phase < N_PHASES; phase++) begin
            settle();
            quiet = (phase % 6 == 3);
            write_reg(REG_PROP_GAIN,  pick_gain(768));
            write_reg(REG_INTEG_GAIN, pick_gain(48));
            write_reg(REG_DERIV_GAIN, pick_gain(384));
            write_reg(REG_INTEG_LIM,  pick_limit());
            write_reg(REG_PWM_TOP,    pick_period());
            if ($urandom_range(0, 3) == 0)
                write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));
            target = 7'($urandom_range(0, 100));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 7) == 0)
                    target = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                                         : 7'($urandom_range(0, 100));
                enable = ($urandom_range(0, 11) != 0);
                send_tick(target, enable, 1'b0, '0);
            end
        end

        settle();
        quiet = 1'b0;
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop: time for about 1600 words at their slowest, taken several times over.
    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
